[design/psg_pkg.sv]
`timescale 1ns / 1ps

package psg_pkg;

  localparam int unsigned COUNT_BITS_DEF = 12;
  localparam int unsigned CFG_W          = 12;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned ROW_W          = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_LEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_SYNC  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_SYNC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_SYNC    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TXT_OFFSET   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TXT_ON       = 3'd6;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_NORMAL_LEN  = 12'd1776;
  localparam logic [CFG_W-1:0] RST_HALF_LEN    = 12'd888;
  localparam logic [CFG_W-1:0] RST_NORMAL_SYNC = 12'd131;
  localparam logic [CFG_W-1:0] RST_SHORT_SYNC  = 12'd65;
  localparam logic [CFG_W-1:0] RST_LONG_SYNC   = 12'd757;
  localparam logic [CFG_W-1:0] RST_TXT_OFFSET  = 12'd280;
  localparam logic             RST_TXT_ON      = 1'b1;

  // Row numbers of the frame
  localparam logic [ROW_W-1:0] ROW_LAST       = 10'd639;
  localparam logic [ROW_W-1:0] ROW_VS1_FIRST  = 10'd305;
  localparam logic [ROW_W-1:0] ROW_VS1_LONG   = 10'd310;
  localparam logic [ROW_W-1:0] ROW_VS1_POST   = 10'd315;
  localparam logic [ROW_W-1:0] ROW_FIELD2     = 10'd319;
  localparam logic [ROW_W-1:0] ROW_VS2_FIRST  = 10'd624;
  localparam logic [ROW_W-1:0] ROW_VS2_SHORT  = 10'd625;
  localparam logic [ROW_W-1:0] ROW_VS2_LONG   = 10'd630;
  localparam logic [ROW_W-1:0] ROW_VS2_POST   = 10'd635;
  localparam logic [ROW_W-1:0] ROW_TXT1_FIRST = 10'd1;
  localparam logic [ROW_W-1:0] ROW_TXT1_LAST  = 10'd16;
  localparam logic [ROW_W-1:0] ROW_TXT2_FIRST = 10'd321;
  localparam logic [ROW_W-1:0] ROW_TXT2_LAST  = 10'd336;
  localparam logic [ROW_W-1:0] ROW_FIELD_END  = 10'd337;

  typedef struct packed {
    logic [CFG_W-1:0] normal_len;
    logic [CFG_W-1:0] half_len;
    logic [CFG_W-1:0] hsync_width;
    logic [CFG_W-1:0] eq_width;
    logic [CFG_W-1:0] broad_width;
    logic [CFG_W-1:0] txt_offset;
    logic             txt_on;
  } cfg_t;

  typedef struct packed {
    logic             sync_active;
    logic [ROW_W-1:0] row_number;
    logic             line_start;
    logic             half_line;
    logic             teletext_trigger;
    logic             field_end;
  } result_t;

  function automatic logic is_half_row(logic [ROW_W-1:0] r);
    is_half_row = ((r >= ROW_VS1_FIRST) && (r < ROW_FIELD2)) || (r >= ROW_VS2_FIRST);
  endfunction

  function automatic logic is_txt_row(logic [ROW_W-1:0] r);
    is_txt_row = ((r >= ROW_TXT1_FIRST) && (r <= ROW_TXT1_LAST)) ||
                 ((r >= ROW_TXT2_FIRST) && (r <= ROW_TXT2_LAST));
  endfunction

endpackage

[design/psg_timing.sv]
`timescale 1ns / 1ps

module psg_timing #(
  parameter int unsigned COUNT_BITS = psg_pkg::COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psg_pkg::cfg_t     cfg_i,
  input  logic              accept_i,
  input  logic              tick_i,
  output psg_pkg::result_t  result_o
);

  localparam int unsigned CMP_W = (COUNT_BITS > psg_pkg::CFG_W) ? COUNT_BITS : psg_pkg::CFG_W;

  logic [COUNT_BITS-1:0]       tick_q, tick_d;
  logic [psg_pkg::ROW_W-1:0]   row_q, row_d;
  logic [COUNT_BITS-1:0]       len_q, len_d;
  logic [COUNT_BITS-1:0]       width_q, width_d;
  logic [COUNT_BITS-1:0]       tick_next;
  logic                        adv;
  logic                        wrap;
  logic                        at_start;
  logic                        at_offset;

  assign adv       = accept_i & tick_i;
  assign tick_next = tick_q + COUNT_BITS'(1);
  // zero length lets the counter run its full range
  assign wrap      = (tick_next == len_q) || (tick_next == '0);
  assign at_start  = (tick_q == '0);
  assign at_offset = (CMP_W'(tick_q) == CMP_W'(cfg_i.txt_offset));

  always_comb begin
    result_o.sync_active      = (tick_q < width_q);
    result_o.row_number       = row_q;
    result_o.line_start       = tick_i & at_start;
    result_o.half_line        = psg_pkg::is_half_row(row_q);
    result_o.teletext_trigger = tick_i & cfg_i.txt_on & psg_pkg::is_txt_row(row_q) & at_offset;
    result_o.field_end        = tick_i & cfg_i.txt_on & (row_q == psg_pkg::ROW_FIELD_END) &
                                at_start;
  end

  always_comb begin
    tick_d  = tick_q;
    row_d   = row_q;
    len_d   = len_q;
    width_d = width_q;
    if (adv) begin
      tick_d = wrap ? '0 : tick_next;
      if (wrap) begin
        row_d = (row_q == psg_pkg::ROW_LAST) ? '0 : row_q + psg_pkg::ROW_W'(1);
        // the new row picks up its length and sync width
        if (row_d == psg_pkg::ROW_VS1_FIRST) begin
          len_d   = COUNT_BITS'(cfg_i.half_len);
          width_d = COUNT_BITS'(cfg_i.eq_width);
        end else if (row_d == psg_pkg::ROW_VS1_LONG || row_d == psg_pkg::ROW_VS2_LONG) begin
          width_d = COUNT_BITS'(cfg_i.broad_width);
        end else if (row_d == psg_pkg::ROW_VS1_POST || row_d == psg_pkg::ROW_VS2_SHORT ||
                     row_d == psg_pkg::ROW_VS2_POST) begin
          width_d = COUNT_BITS'(cfg_i.eq_width);
        end else if (row_d == psg_pkg::ROW_VS2_FIRST) begin
          len_d = COUNT_BITS'(cfg_i.half_len);
        end else if (row_d == '0 || row_d == psg_pkg::ROW_FIELD2) begin
          len_d   = COUNT_BITS'(cfg_i.normal_len);
          width_d = COUNT_BITS'(cfg_i.hsync_width);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      row_q   <= '0;
      len_q   <= COUNT_BITS'(psg_pkg::RST_NORMAL_LEN);
      width_q <= COUNT_BITS'(psg_pkg::RST_NORMAL_SYNC);
    end else begin
      tick_q  <= tick_d;
      row_q   <= row_d;
      len_q   <= len_d;
      width_q <= width_d;
    end
  end

endmodule

[design/psg_out_buf.sv]
`timescale 1ns / 1ps

// Two-entry result queue: the input side keeps moving while a result waits.
module psg_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  psg_pkg::result_t  data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output psg_pkg::result_t  data_o
);

  logic [1:0]        count_q, count_d;
  psg_pkg::result_t  head_q, tail_q;
  logic              pop;

  assign pop     = valid_o & ready_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = head_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && pop) begin
      if (count_q == 2'd1) begin
        head_q <= data_i;
      end else begin
        head_q <= tail_q;
        tail_q <= data_i;
      end
    end else if (push_i) begin
      if (count_q == 2'd0) begin
        head_q <= data_i;
      end else begin
        tail_q <= data_i;
      end
    end else if (pop) begin
      head_q <= tail_q;
    end
  end

endmodule

[design/pal_sync_pulse_generator.sv]
`timescale 1ns / 1ps
// Each accepted input's result is registered into the result queue.
// Throughput: one tick per cycle unless the result queue is full.
// A two-entry result queue lets input transfers continue while one result waits.
// Reset: tick 0, row 0, normal line length and sync width, registers at their
// defaults, result queue empty.
module pal_sync_pulse_generator #(
  parameter int unsigned COUNT_BITS = psg_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            tick_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            sync_active_o,
  output logic [psg_pkg::ROW_W-1:0]       row_number_o,
  output logic                            line_start_o,
  output logic                            half_line_o,
  output logic                            teletext_trigger_o,
  output logic                            field_end_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [psg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [psg_pkg::CFG_W-1:0]       cfg_data_i
);

  psg_pkg::cfg_t     cfg_q;
  psg_pkg::result_t  result;
  psg_pkg::result_t  out_data;
  logic              accept;
  logic              buf_full;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~buf_full;
  assign accept      = in_valid_i & ~buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_len  <= psg_pkg::RST_NORMAL_LEN;
      cfg_q.half_len    <= psg_pkg::RST_HALF_LEN;
      cfg_q.hsync_width <= psg_pkg::RST_NORMAL_SYNC;
      cfg_q.eq_width    <= psg_pkg::RST_SHORT_SYNC;
      cfg_q.broad_width <= psg_pkg::RST_LONG_SYNC;
      cfg_q.txt_offset  <= psg_pkg::RST_TXT_OFFSET;
      cfg_q.txt_on      <= psg_pkg::RST_TXT_ON;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        psg_pkg::REG_NORMAL_LEN:  cfg_q.normal_len  <= cfg_data_i;
        psg_pkg::REG_HALF_LEN:    cfg_q.half_len    <= cfg_data_i;
        psg_pkg::REG_NORMAL_SYNC: cfg_q.hsync_width <= cfg_data_i;
        psg_pkg::REG_SHORT_SYNC:  cfg_q.eq_width    <= cfg_data_i;
        psg_pkg::REG_LONG_SYNC:   cfg_q.broad_width <= cfg_data_i;
        psg_pkg::REG_TXT_OFFSET:  cfg_q.txt_offset  <= cfg_data_i;
        psg_pkg::REG_TXT_ON:      cfg_q.txt_on      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  psg_timing #(
    .COUNT_BITS(COUNT_BITS)
  ) u_timing (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .tick_i   (tick_i),
    .result_o (result)
  );

  psg_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign sync_active_o      = out_data.sync_active;
  assign row_number_o       = out_data.row_number;
  assign line_start_o       = out_data.line_start;
  assign half_line_o        = out_data.half_line;
  assign teletext_trigger_o = out_data.teletext_trigger;
  assign field_end_o        = out_data.field_end;

endmodule

[design/psg_checker.sv]
`timescale 1ns / 1ps

module psg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          sync_active_o,
  input logic [psg_pkg::ROW_W-1:0]     row_number_o,
  input logic                          line_start_o,
  input logic                          half_line_o,
  input logic                          teletext_trigger_o,
  input logic                          field_end_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_number_o) &&
      $stable(sync_active_o) && $stable(line_start_o))
    else $error("stalled result changed");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> row_number_o <= psg_pkg::ROW_LAST)
    else $error("row out of frame");

  a_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> half_line_o == psg_pkg::is_half_row(row_number_o))
    else $error("half line flag mismatch");

  a_field_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_end_o |-> line_start_o && row_number_o == psg_pkg::ROW_FIELD_END)
    else $error("field end off its row start");

  a_txt_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && teletext_trigger_o |-> psg_pkg::is_txt_row(row_number_o))
    else $error("teletext trigger outside teletext rows");

endmodule

bind pal_sync_pulse_generator psg_checker u_psg_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .sync_active_o      (sync_active_o),
  .row_number_o       (row_number_o),
  .line_start_o       (line_start_o),
  .half_line_o        (half_line_o),
  .teletext_trigger_o (teletext_trigger_o),
  .field_end_o        (field_end_o)
);
